### rtl/core/arc_pkg.sv
// arc_pkg: shared types and constants of the audio rate converter
// no dependencies; imported by every module of the block

package arc_pkg;

   // history store
   localparam int HIST_DEPTH   = 128;
   localparam int HIST_AW      = $clog2(HIST_DEPTH);
   localparam int AVAIL_W      = HIST_AW + 1;

   // step format
   localparam int PHASE_BITS   = 22;
   localparam int STEP_W       = 29;
   localparam int MAX_RATIO    = 64;
   localparam int RESULT_LIMIT = 64;
   localparam int CNT_W        = $clog2(RESULT_LIMIT + 1);
   localparam int WEIGHT_BITS  = 12;
   localparam int BOX_BITS     = 8;
   localparam int SMALL_W      = STEP_W - (PHASE_BITS - BOX_BITS);

   localparam logic [STEP_W-1:0] STEP_ONE =
      STEP_W'(64'd1 << PHASE_BITS);
   localparam logic [STEP_W-1:0] STEP_LO  =
      STEP_W'(((64'd1 << PHASE_BITS) + MAX_RATIO - 1) / MAX_RATIO);
   localparam logic [STEP_W-1:0] STEP_HI  =
      STEP_W'((64'd1 << PHASE_BITS) * MAX_RATIO);

   // datapath widths
   localparam int SAMPLE_W = 16;
   localparam int TAPW_W   = WEIGHT_BITS + 2;
   localparam int PROD_W   = SAMPLE_W + TAPW_W;
   localparam int ACC_W    = 32;
   localparam int SRES_W   = 18;
   localparam int GAIN_W   = 24;
   localparam int GPROD_W  = SRES_W + GAIN_W;
   localparam int OUT_W    = 32;

   // configuration register indexes
   localparam logic [1:0] CSR_RATE_STEP   = 2'd0;
   localparam logic [1:0] CSR_INPUT_GAIN  = 2'd1;
   localparam logic [1:0] CSR_OUTPUT_GAIN = 2'd2;

   // conversion mode of one result
   typedef enum logic [1:0] {
      MODE_COPY   = 2'd0,
      MODE_INTERP = 2'd1,
      MODE_DECIM  = 2'd2
   } mode_type;

   typedef struct packed {
      logic [STEP_W-1:0]          rate_step;
      logic signed [SAMPLE_W-1:0] input_gain;
      logic signed [SAMPLE_W-1:0] output_gain;
   } cfg_type;

   typedef struct packed {
      logic                    start;
      logic signed [ACC_W-1:0] dividend;
      logic [SMALL_W-1:0]      divisor;
   } div_req_type;

   typedef struct packed {
      logic                    done;
      logic signed [ACC_W-1:0] quotient;
   } div_rsp_type;

endpackage

### rtl/core/arc_front.sv
// arc_front: request side of the converter, a two-entry sample queue
// depends on arc_pkg

module arc_front
   import arc_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   input  logic [SAMPLE_W-1:0] req_tdata,
   output logic                q_valid,
   output logic [SAMPLE_W-1:0] q_sample,
   input  logic                q_pop
);

   logic [SAMPLE_W-1:0] slot_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       push, pop;

   // handshake
   assign req_tready = (count_ff != 2'd2);
   assign push       = req_tvalid && req_tready;
   assign q_valid    = (count_ff != 2'd0);
   assign pop        = q_pop && q_valid;
   assign q_sample   = slot_ff[rd_ptr_ff];

   // pointer and fill update
   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ push;
      rd_ptr_in = rd_ptr_ff ^ pop;
      count_in  = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // queue storage
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= req_tdata;
      end
   end

endmodule

### rtl/core/arc_div.sv
// arc_div: signed-by-unsigned divider, one quotient bit per cycle, truncates toward zero
// depends on arc_pkg

module arc_div
   import arc_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  div_req_type req,
   output div_rsp_type rsp
);

   localparam int CW = $clog2(ACC_W);

   logic                busy_ff, busy_in;
   logic                done_ff, done_in;
   logic [CW-1:0]       cnt_ff, cnt_in;
   logic                neg_ff, neg_in;
   logic [ACC_W-1:0]    mag_ff, mag_in;
   logic [SMALL_W-1:0]  rem_ff, rem_in;
   logic [SMALL_W-1:0]  dsr_ff, dsr_in;
   logic [ACC_W-1:0]    quo_ff, quo_in;
   logic [SMALL_W:0]    trial;
   logic                fits;

   // one restoring step
   always_comb begin
      trial = {rem_ff, mag_ff[ACC_W-1]};
      fits  = (trial >= {1'b0, dsr_ff});
   end

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      neg_in  = neg_ff;
      mag_in  = mag_ff;
      rem_in  = rem_ff;
      dsr_in  = dsr_ff;
      quo_in  = quo_ff;
      if (req.start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         neg_in  = req.dividend[ACC_W-1];
         mag_in  = req.dividend[ACC_W-1] ? ACC_W'(-req.dividend) : req.dividend;
         rem_in  = '0;
         dsr_in  = req.divisor;
      end else if (busy_ff) begin
         rem_in = fits ? SMALL_W'(trial - {1'b0, dsr_ff}) : trial[SMALL_W-1:0];
         mag_in = {mag_ff[ACC_W-2:0], fits};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CW'(ACC_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
            quo_in  = neg_ff ? ACC_W'(-{mag_ff[ACC_W-2:0], fits})
                             : {mag_ff[ACC_W-2:0], fits};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff <= cnt_in;
      neg_ff <= neg_in;
      mag_ff <= mag_in;
      rem_ff <= rem_in;
      dsr_ff <= dsr_in;
      quo_ff <= quo_in;
   end

   assign rsp.done     = done_ff;
   assign rsp.quotient = quo_ff;

endmodule

### rtl/core/arc_engine.sv
// arc_engine: back end of the converter; history store, tap sequencer,
// gain stage and response register. depends on arc_pkg, uses arc_div

module arc_engine
   import arc_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  cfg_type             cfg,
   input  logic                q_valid,
   input  logic [SAMPLE_W-1:0] q_sample,
   output logic                q_pop,
   output div_req_type         div_req,
   input  div_rsp_type         div_rsp,
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   output logic [OUT_W-1:0]    rsp_tdata,
   output logic                rsp_tlast
);

   typedef enum logic [6:0] {
      ST_IDLE = 7'b0000001,
      ST_PLAN = 7'b0000010,
      ST_TAPS = 7'b0000100,
      ST_DIV  = 7'b0001000,
      ST_GAIN = 7'b0010000,
      ST_ADV  = 7'b0100000,
      ST_EMIT = 7'b1000000
   } state_type;

   localparam int SPAN_W = PHASE_BITS + 1;
   localparam int ADV_W  = STEP_W + 1 - PHASE_BITS;

   // history store; every tap read lies inside the held window, so the
   // entries need no clearing after reset
   logic [SAMPLE_W-1:0] hist_mem [HIST_DEPTH];

   state_type            state_ff;
   logic [HIST_AW-1:0]   wr_ptr_ff;
   logic [HIST_AW-1:0]   win_ptr_ff;
   logic [AVAIL_W-1:0]   avail_ff;
   logic [PHASE_BITS-1:0] phase_ff;
   logic [CNT_W-1:0]     cnt_ff;
   logic signed [GAIN_W-1:0] gain_ff;
   mode_type             mode_ff;
   logic [HIST_AW-1:0]   last_ff;
   logic [TAPW_W-1:0]    w0_ff, wl_ff;
   logic [SMALL_W-1:0]   small_ff;
   logic [HIST_AW:0]     tap_idx_ff;
   logic                 v1_ff, v2_ff;
   logic [SAMPLE_W-1:0]  rd_ff;
   logic [TAPW_W-1:0]    w1_ff;
   logic signed [PROD_W-1:0]  prod_ff;
   logic signed [ACC_W-1:0]   acc_ff;
   logic signed [GPROD_W-1:0] gprod_ff;
   logic [OUT_W-1:0]     result_ff;
   logic                 rsp_valid_ff;
   logic [OUT_W-1:0]     rsp_data_ff;
   logic                 rsp_last_ff;

   logic [STEP_W-1:0]    step;
   mode_type             plan_mode;
   logic [WEIGHT_BITS-1:0] frac_w;
   logic [SPAN_W-1:0]    span;
   logic [BOX_BITS:0]    scale;
   logic [SMALL_W-1:0]   small_v;
   logic [SMALL_W-1:0]   rem_v;
   logic [SMALL_W-1:0]   rem_up;
   logic [HIST_AW-1:0]   box_last;
   logic [SMALL_W-1:0]   box_base;
   logic [HIST_AW-1:0]   plan_last;
   logic [TAPW_W-1:0]    plan_w0, plan_wl;
   logic [AVAIL_W-1:0]   need;
   logic                 can_go;
   logic                 more;
   logic                 issuing;
   logic                 taps_done;
   logic [TAPW_W-1:0]    tap_w;
   logic signed [SRES_W-1:0] s_val;
   logic signed [OUT_W-1:0]  gain_full;
   logic                 load;
   logic                 out_free;
   logic [STEP_W:0]      phase_sum;
   logic [ADV_W-1:0]     adv;
   logic [AVAIL_W-1:0]   take;

   // clamp the step to the supported ratio range
   always_comb begin
      priority if (cfg.rate_step < STEP_LO) begin
         step = STEP_LO;
      end else if (cfg.rate_step > STEP_HI) begin
         step = STEP_HI;
      end else begin
         step = cfg.rate_step;
      end
   end

   // plan of the next result from the current phase
   always_comb begin
      frac_w   = phase_ff[PHASE_BITS-1 -: WEIGHT_BITS];
      span     = SPAN_W'(64'd1 << PHASE_BITS) - {1'b0, phase_ff};
      scale    = span[SPAN_W-1 -: BOX_BITS+1];
      small_v  = step[STEP_W-1 -: SMALL_W];
      rem_v    = small_v - SMALL_W'(scale);
      rem_up   = rem_v + SMALL_W'((1 << BOX_BITS) - 1);
      box_last = (rem_v == '0) ? HIST_AW'(1) : HIST_AW'(rem_up >> BOX_BITS);
      box_base = SMALL_W'(box_last - 1'b1) << BOX_BITS;
      priority if (step == STEP_ONE) begin
         plan_mode = MODE_COPY;
         plan_last = '0;
         plan_w0   = TAPW_W'(1);
         plan_wl   = TAPW_W'(1);
      end else if (step < STEP_ONE) begin
         plan_mode = MODE_INTERP;
         plan_last = HIST_AW'(1);
         plan_w0   = TAPW_W'(1 << WEIGHT_BITS) - TAPW_W'(frac_w);
         plan_wl   = TAPW_W'(frac_w);
      end else begin
         plan_mode = MODE_DECIM;
         plan_last = box_last;
         plan_w0   = TAPW_W'(scale);
         plan_wl   = TAPW_W'(rem_v - box_base);
      end
      need   = AVAIL_W'(plan_last) + 1'b1;
      can_go = (avail_ff >= need);
      more   = (cnt_ff < CNT_W'(RESULT_LIMIT)) && can_go;
   end

   // tap sequencing and weight selection
   always_comb begin
      issuing   = (tap_idx_ff <= {1'b0, last_ff});
      taps_done = !issuing && !v1_ff && !v2_ff;
      priority if (tap_idx_ff == '0) begin
         tap_w = w0_ff;
      end else if (tap_idx_ff == {1'b0, last_ff}) begin
         tap_w = wl_ff;
      end else begin
         tap_w = TAPW_W'(1 << BOX_BITS);
      end
   end

   // result before gain
   always_comb begin
      unique case (mode_ff)
         MODE_COPY:   s_val = acc_ff[SRES_W-1:0];
         MODE_INTERP: s_val = acc_ff[SRES_W+WEIGHT_BITS-1:WEIGHT_BITS];
         MODE_DECIM:  s_val = div_rsp.quotient[SRES_W-1:0];
         default:     s_val = acc_ff[SRES_W-1:0];
      endcase
   end

   // phase advance and window consumption
   always_comb begin
      phase_sum = {{(STEP_W+1-PHASE_BITS){1'b0}}, phase_ff} + {1'b0, step};
      if (mode_ff == MODE_COPY) begin
         adv = ADV_W'(1);
      end else begin
         adv = phase_sum[STEP_W:PHASE_BITS];
      end
      take = (ADV_W'(avail_ff) <= adv) ? avail_ff : AVAIL_W'(adv);
   end

   assign gain_full = cfg.input_gain * cfg.output_gain;
   assign out_free  = !rsp_valid_ff || rsp_tready;
   assign load      = (state_ff == ST_EMIT) && out_free;
   assign q_pop     = (state_ff == ST_IDLE) && q_valid;

   assign div_req.start    = (state_ff == ST_TAPS) && taps_done && (mode_ff == MODE_DECIM);
   assign div_req.dividend = acc_ff;
   assign div_req.divisor  = small_ff;

   // control sequencer
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         wr_ptr_ff  <= '0;
         win_ptr_ff <= '0;
         avail_ff   <= '0;
         phase_ff   <= '0;
         cnt_ff     <= '0;
         tap_idx_ff <= '0;
         last_ff    <= '0;
      end else begin
         unique case (state_ff)
            ST_IDLE: begin
               if (q_valid) begin
                  if (avail_ff >= AVAIL_W'(HIST_DEPTH)) begin
                     win_ptr_ff <= win_ptr_ff + 1'b1;
                     avail_ff   <= avail_ff;
                  end else begin
                     avail_ff <= avail_ff + 1'b1;
                  end
                  wr_ptr_ff <= wr_ptr_ff + 1'b1;
                  cnt_ff    <= '0;
                  state_ff  <= ST_PLAN;
               end
            end
            ST_PLAN: begin
               if (can_go) begin
                  tap_idx_ff <= '0;
                  last_ff    <= plan_last;
                  state_ff   <= ST_TAPS;
               end else begin
                  state_ff <= ST_IDLE;
               end
            end
            ST_TAPS: begin
               if (issuing) begin
                  tap_idx_ff <= tap_idx_ff + 1'b1;
               end
               if (taps_done) begin
                  state_ff <= (mode_ff == MODE_DECIM) ? ST_DIV : ST_GAIN;
               end
            end
            ST_DIV: begin
               if (div_rsp.done) begin
                  state_ff <= ST_GAIN;
               end
            end
            ST_GAIN: begin
               state_ff <= ST_ADV;
            end
            ST_ADV: begin
               if (mode_ff != MODE_COPY) begin
                  phase_ff <= phase_sum[PHASE_BITS-1:0];
               end
               win_ptr_ff <= win_ptr_ff + take[HIST_AW-1:0];
               avail_ff   <= avail_ff - take;
               cnt_ff     <= cnt_ff + 1'b1;
               state_ff   <= ST_EMIT;
            end
            ST_EMIT: begin
               if (out_free) begin
                  if (more) begin
                     tap_idx_ff <= '0;
                     last_ff    <= plan_last;
                     state_ff   <= ST_TAPS;
                  end else begin
                     state_ff <= ST_IDLE;
                  end
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   // plan latch and gain product, payload only
   always_ff @(posedge clock) begin
      if ((state_ff == ST_PLAN) || load) begin
         mode_ff  <= plan_mode;
         w0_ff    <= plan_w0;
         wl_ff    <= plan_wl;
         small_ff <= small_v;
      end
      if (q_pop) begin
         gain_ff <= gain_full[OUT_W-1:OUT_W-GAIN_W];
      end
      if (state_ff == ST_GAIN) begin
         gprod_ff <= s_val * gain_ff;
      end
      if (state_ff == ST_ADV) begin
         result_ff <= {{8{gprod_ff[OUT_W-1]}}, gprod_ff[OUT_W-1:8]};
      end
   end

   // history write and registered tap read
   always_ff @(posedge clock) begin
      if (q_pop) begin
         hist_mem[wr_ptr_ff] <= q_sample;
      end
      rd_ff <= hist_mem[win_ptr_ff + tap_idx_ff[HIST_AW-1:0]];
   end

   // multiply-accumulate pipeline
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else begin
         v1_ff <= (state_ff == ST_TAPS) && issuing;
         v2_ff <= v1_ff;
      end
   end

   always_ff @(posedge clock) begin
      w1_ff   <= tap_w;
      prod_ff <= $signed(rd_ff) * $signed(w1_ff);
      if ((state_ff == ST_PLAN) || load) begin
         acc_ff <= '0;
      end else if (v2_ff) begin
         acc_ff <= acc_ff + ACC_W'(prod_ff);
      end
   end

   // response register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         rsp_data_ff <= result_ff;
         rsp_last_ff <= !more;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;

endmodule

### rtl/core/audio_rate_converter_top.sv
// audio_rate_converter_top: top level of the audio sample-rate converter
// depends on arc_pkg, arc_front, arc_div, arc_engine
//
// usage:
//   req_* carries one 16-bit source sample per request. rsp_* carries the
//   destination-rate samples that the request releases, zero to 64 of them;
//   rsp_tlast marks the last one of a request. a request that releases
//   nothing yields no response.
//   csr_* writes rate_step (index 0), input_gain (1) and output_gain (2);
//   write only while the block is idle.
// datapath:
//   a result is formed by the single multiply-accumulate pipe, which reads
//   one history tap per cycle, and in decimation mode also by the one-bit-
//   per-cycle divider; taps is 1, 2 or up to 65 in decimation. each request
//   also passes the history write and planning states.
// reset: history pointers, phase and config return to their reset values
//   at once; no clearing pass. a two-entry queue takes requests while the
//   back end works. a stalled receiver holds the response register, and
//   the back end waits on it once the next result is ready.

module audio_rate_converter_top
   import arc_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   // fields: in_sample[15:0]
   input  logic                req_tvalid,
   output logic                req_tready,
   input  logic [SAMPLE_W-1:0] req_tdata,
   // fields: out_sample[31:0]
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   output logic [OUT_W-1:0]    rsp_tdata,
   output logic                rsp_tlast,
   input  logic                csr_we,
   input  logic [1:0]          csr_index,
   input  logic [STEP_W-1:0]   csr_wdata
);

   cfg_type             cfg_ff;
   logic                q_valid;
   logic [SAMPLE_W-1:0] q_sample;
   logic                q_pop;
   div_req_type         div_req;
   div_rsp_type         div_rsp;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.rate_step   <= STEP_ONE;
         cfg_ff.input_gain  <= 16'sd256;
         cfg_ff.output_gain <= 16'sd256;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_RATE_STEP:   cfg_ff.rate_step   <= csr_wdata;
            CSR_INPUT_GAIN:  cfg_ff.input_gain  <= csr_wdata[SAMPLE_W-1:0];
            CSR_OUTPUT_GAIN: cfg_ff.output_gain <= csr_wdata[SAMPLE_W-1:0];
            default: ;
         endcase
      end
   end

   arc_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .q_valid    (q_valid),
      .q_sample   (q_sample),
      .q_pop      (q_pop)
   );

   arc_div u_div (
      .clock (clock),
      .reset (reset),
      .req   (div_req),
      .rsp   (div_rsp)
   );

   arc_engine u_engine (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .q_valid    (q_valid),
      .q_sample   (q_sample),
      .q_pop      (q_pop),
      .div_req    (div_req),
      .div_rsp    (div_rsp),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

### rtl/core/arc_checker.sv
// arc_checker: port-level assertions of the audio rate converter
// depends on arc_pkg; bound to audio_rate_converter_top

module arc_checker
   import arc_pkg::*;
(
   input logic                clock,
   input logic                reset,
   input logic                req_tready,
   input logic                rsp_tvalid,
   input logic                rsp_tready,
   input logic [OUT_W-1:0]    rsp_tdata,
   input logic                rsp_tlast
);

   // a stalled response keeps its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("response payload changed while stalled");

   // a stalled response stays valid
   a_rsp_keep: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("response dropped while stalled");

   // reset empties the response register
   a_rst_rsp: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("response valid right after reset");

   // reset empties the request queue
   a_rst_req: assert property (@(posedge clock)
      reset |=> req_tready)
      else $error("request side not ready after reset");

endmodule

bind audio_rate_converter_top arc_checker u_arc_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast)
);
